FILE: rtl/rc5_block_cipher_assert.svh
// ----------------------------------------------------------------------------
// rc5 block cipher assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef RC5_BLOCK_CIPHER_ASSERT_SVH
`define RC5_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// check that holds outside reset
`define RC5_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that holds at every edge, reset included
`define RC5_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RC5_ASSERT(lbl, clk, rstn, prop, msg)
`define RC5_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/rc5_pkg.sv
// ----------------------------------------------------------------------------
// rc5 package
// shared constants, types, rotate helpers and the control-store program
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc5_pkg;

  localparam int ROUNDS      = 12;
  localparam int KEY_WORDS   = 4;
  localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
  localparam int MIX_STEPS   = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);
  localparam int PTR_W       = $clog2(TABLE_WORDS);
  localparam int CNT_W       = $clog2(MIX_STEPS);
  localparam int KSEL_W      = $clog2(KEY_WORDS);
  localparam int CFG_AW      = $clog2(KEY_WORDS * 4);

  localparam logic [31:0] MAGIC_P = 32'hb7e15163;
  localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

  typedef enum logic [1:0] {
    OP_ENC    = 2'd0,
    OP_DEC    = 2'd1,
    OP_EXPAND = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] in_left;
    logic [31:0] in_right;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_left;
    logic [31:0] out_right;
    logic        status;
  } out_item_t;

  typedef enum logic [3:0] {
    A_HOLD, A_ADD_RD, A_SUB_RD, A_ENC, A_DEC, A_LOAD_P, A_ADD_Q, A_ZERO, A_MIX
  } a_op_t;

  typedef enum logic [2:0] {
    B_HOLD, B_ADD_RD, B_SUB_RD, B_ENC, B_DEC, B_ZERO, B_MIX
  } b_op_t;

  typedef enum logic [1:0] {
    PTR_HOLD, PTR_INC, PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    LIM_ROUNDS, LIM_TABLE, LIM_MIX
  } lim_t;

  // control-store layout
  localparam int NUM_STEPS = 18;
  localparam int PC_W      = $clog2(NUM_STEPS);

  localparam logic [PC_W-1:0] PC_E_K0   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_E_K1   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_E_HA   = PC_W'(2);
  localparam logic [PC_W-1:0] PC_E_HB   = PC_W'(3);
  localparam logic [PC_W-1:0] PC_E_DONE = PC_W'(4);
  localparam logic [PC_W-1:0] PC_D_HB   = PC_W'(5);
  localparam logic [PC_W-1:0] PC_D_HA   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_D_K1   = PC_W'(7);
  localparam logic [PC_W-1:0] PC_D_K0   = PC_W'(8);
  localparam logic [PC_W-1:0] PC_D_DONE = PC_W'(9);
  localparam logic [PC_W-1:0] PC_X_INIT = PC_W'(10);
  localparam logic [PC_W-1:0] PC_X_FILL = PC_W'(11);
  localparam logic [PC_W-1:0] PC_X_ZERO = PC_W'(12);
  localparam logic [PC_W-1:0] PC_X_MA   = PC_W'(13);
  localparam logic [PC_W-1:0] PC_X_MB   = PC_W'(14);
  localparam logic [PC_W-1:0] PC_X_DONE = PC_W'(15);
  localparam logic [PC_W-1:0] PC_N_DONE = PC_W'(16);
  localparam logic [PC_W-1:0] PC_F_DONE = PC_W'(17);

  typedef struct packed {
    a_op_t             a_op;
    b_op_t             b_op;
    ptr_op_t           ptr_op;
    logic              ram_we;
    logic              ks_load;
    logic              ks_wr;
    logic              out_en;
    logic              out_blk;
    logic              status;
    logic              set_ready;
    logic              jump;
    lim_t              lim;
    logic [PC_W-1:0]   target;
    logic              last;
  } ctrl_t;

  localparam ctrl_t CW_NOP = '{
    a_op: A_HOLD, b_op: B_HOLD, ptr_op: PTR_HOLD, ram_we: 1'b0, ks_load: 1'b0,
    ks_wr: 1'b0, out_en: 1'b0, out_blk: 1'b0, status: 1'b0, set_ready: 1'b0,
    jump: 1'b0, lim: LIM_ROUNDS, target: PC_E_K0, last: 1'b0
  };

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

  // final count of a loop before it falls through
  function automatic logic [CNT_W-1:0] lim_value(input lim_t l);
    logic [CNT_W-1:0] v;
    unique case (l)
      LIM_ROUNDS: v = CNT_W'(ROUNDS - 1);
      LIM_TABLE:  v = CNT_W'(TABLE_WORDS - 1);
      LIM_MIX:    v = CNT_W'(MIX_STEPS - 1);
      default:    v = '0;
    endcase
    return v;
  endfunction

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    cw = CW_NOP;
    unique case (pc)
      PC_E_K0: begin
        cw.a_op = A_ADD_RD; cw.ptr_op = PTR_INC;
      end
      PC_E_K1: begin
        cw.b_op = B_ADD_RD; cw.ptr_op = PTR_INC;
      end
      PC_E_HA: begin
        cw.a_op = A_ENC; cw.ptr_op = PTR_INC;
      end
      PC_E_HB: begin
        cw.b_op = B_ENC; cw.ptr_op = PTR_INC;
        cw.jump = 1'b1; cw.lim = LIM_ROUNDS; cw.target = PC_E_HA;
      end
      PC_E_DONE, PC_D_DONE: begin
        cw.out_en = 1'b1; cw.out_blk = 1'b1; cw.last = 1'b1;
      end
      PC_D_HB: begin
        cw.b_op = B_DEC; cw.ptr_op = PTR_DEC;
      end
      PC_D_HA: begin
        cw.a_op = A_DEC; cw.ptr_op = PTR_DEC;
        cw.jump = 1'b1; cw.lim = LIM_ROUNDS; cw.target = PC_D_HB;
      end
      PC_D_K1: begin
        cw.b_op = B_SUB_RD; cw.ptr_op = PTR_DEC;
      end
      PC_D_K0: begin
        cw.a_op = A_SUB_RD;
      end
      PC_X_INIT: begin
        cw.a_op = A_LOAD_P; cw.ks_load = 1'b1;
      end
      PC_X_FILL: begin
        cw.a_op = A_ADD_Q; cw.ram_we = 1'b1; cw.ptr_op = PTR_INC;
        cw.jump = 1'b1; cw.lim = LIM_TABLE; cw.target = PC_X_FILL;
      end
      PC_X_ZERO: begin
        cw.a_op = A_ZERO; cw.b_op = B_ZERO;
      end
      PC_X_MA: begin
        cw.a_op = A_MIX; cw.ram_we = 1'b1;
      end
      PC_X_MB: begin
        cw.b_op = B_MIX; cw.ks_wr = 1'b1; cw.ptr_op = PTR_INC;
        cw.jump = 1'b1; cw.lim = LIM_MIX; cw.target = PC_X_MA;
      end
      PC_X_DONE: begin
        cw.out_en = 1'b1; cw.set_ready = 1'b1; cw.last = 1'b1;
      end
      PC_N_DONE: begin
        cw.out_en = 1'b1; cw.last = 1'b1;
      end
      PC_F_DONE: begin
        cw.out_en = 1'b1; cw.status = 1'b1; cw.last = 1'b1;
      end
      default: begin
        cw.last = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rc5_block_cipher.sv
// ----------------------------------------------------------------------------
// rc5 block cipher (32-bit words, 12 rounds, 128-bit key)
// microcoded sequencer over a shared a/b datapath and a round-key table ram
// ----------------------------------------------------------------------------
//   channel   direction   handshake                   payload
//   in        request     start / busy                in_data   (rc5_pkg::in_item_t)
//   out       result      out_strobe, one cycle       out_data  (rc5_pkg::out_item_t)
//   cfg       register    psel/penable/pwrite/pready  key words 0..3 at 0x0..0xc
//
// after accept, encrypt and decrypt run one half-round per step through the
// single a/b update unit; expand fills the table through the ram write port,
// then mixes the key into it in a two-step loop. fault and unused
// operations go straight to their result step.
// the strobe comes the cycle after the last step; busy drops in that cycle,
// so the next request can be taken while the result is on the ports.
// reset clears the sequencer, the key words and the expanded flag; the round
// key table needs no clearing. the result side never stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc5_block_cipher (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rc5_pkg::in_item_t           in_data,
  output logic                             out_strobe,
  output rc5_pkg::out_item_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rc5_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [rc5_pkg::KEY_WORDS-1:0][31:0] key_r;
  logic [rc5_pkg::KSEL_W-1:0]          reg_sel;
  logic                                cfg_wr;
  logic                                in_acc;
  rc5_pkg::ctrl_t                      ctrl;

  assign pready  = 1'b1;
  assign reg_sel = paddr[rc5_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = key_r[reg_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_wr) begin
      key_r[reg_sel] <= pwdata;
    end
  end

  assign in_acc = start && !busy;

  rc5_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  rc5_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_data    (in_data),
    .ctrl       (ctrl),
    .key_words  (key_r),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/rc5_ram.sv
// ----------------------------------------------------------------------------
// rc5 generic ram
// single write port, single read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/rc5_seq.sv
// ----------------------------------------------------------------------------
// rc5 sequencer
// step counter, loop counter and control store; picks the program entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc5_block_cipher_assert.svh"

module rc5_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire rc5_pkg::op_t  operation,
  output logic               busy,
  output rc5_pkg::ctrl_t     ctrl
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t                   state_r, state_nxt;
  logic [rc5_pkg::PC_W-1:0]     pc_r, pc_nxt;
  logic [rc5_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         keys_ready_r, keys_ready_nxt;
  logic [rc5_pkg::PC_W-1:0]     entry;
  rc5_pkg::ctrl_t               cw;
  logic                         loop_back;

  assign cw   = rc5_pkg::ucode(pc_r);
  assign busy = (state_r == SQ_RUN);
  assign ctrl = busy ? cw : rc5_pkg::CW_NOP;

  always_comb begin
    unique case (operation)
      rc5_pkg::OP_ENC:    entry = keys_ready_r ? rc5_pkg::PC_E_K0 : rc5_pkg::PC_F_DONE;
      rc5_pkg::OP_DEC:    entry = keys_ready_r ? rc5_pkg::PC_D_HB : rc5_pkg::PC_F_DONE;
      rc5_pkg::OP_EXPAND: entry = rc5_pkg::PC_X_INIT;
      rc5_pkg::OP_NONE:   entry = rc5_pkg::PC_N_DONE;
      default:            entry = rc5_pkg::PC_N_DONE;
    endcase
  end

  assign loop_back = cw.jump && (cnt_r != rc5_pkg::lim_value(cw.lim));

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    keys_ready_nxt = keys_ready_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          state_nxt = SQ_RUN;
          pc_nxt    = entry;
          cnt_nxt   = '0;
        end
      end
      SQ_RUN: begin
        if (cw.set_ready) begin
          keys_ready_nxt = 1'b1;
        end
        if (cw.last) begin
          state_nxt = SQ_IDLE;
        end else if (loop_back) begin
          pc_nxt  = cw.target;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          pc_nxt = pc_r + 1'b1;
          // loop exit clears the count for the next loop
          if (cw.jump) begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SQ_IDLE;
      pc_r         <= '0;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      cnt_r        <= cnt_nxt;
      keys_ready_r <= keys_ready_nxt;
    end
  end

  `RC5_ASSERT(a_start_runs, clk, rst_n, start && !busy |=> busy, "request accepted but sequencer idle")
  `RC5_ASSERT(a_last_ends, clk, rst_n, busy && cw.last |=> !busy, "program end did not release busy")
  `RC5_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= rc5_pkg::lim_value(rc5_pkg::LIM_MIX), "loop count out of range")

endmodule

`default_nettype wire

FILE: rtl/rc5_datapath.sv
// ----------------------------------------------------------------------------
// rc5 datapath
// a/b word registers, key scratch, round-key table pointer and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rc5_block_cipher_assert.svh"

module rc5_datapath (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_acc,
  input  wire rc5_pkg::in_item_t                         in_data,
  input  wire rc5_pkg::ctrl_t                            ctrl,
  input  wire logic [rc5_pkg::KEY_WORDS-1:0][31:0]       key_words,
  output logic                                           out_strobe,
  output rc5_pkg::out_item_t                             out_data
);

  localparam logic [rc5_pkg::PTR_W-1:0] PTR_LAST = rc5_pkg::PTR_W'(rc5_pkg::TABLE_WORDS - 1);

  logic [31:0]                 a_r, a_nxt;
  logic [31:0]                 b_r, b_nxt;
  logic [rc5_pkg::PTR_W-1:0]   i_r, i_nxt;
  logic [rc5_pkg::KSEL_W-1:0]  j_r, j_nxt;
  logic [31:0]                 ks_r [rc5_pkg::KEY_WORDS];
  logic [31:0]                 rd;
  logic [31:0]                 wdata;
  logic [31:0]                 ab_sum;
  logic                        out_strobe_r;
  rc5_pkg::out_item_t          out_r;

  assign ab_sum = a_r + b_r;

  always_comb begin
    a_nxt = a_r;
    if (in_acc) begin
      a_nxt = in_data.in_left;
    end else begin
      unique case (ctrl.a_op)
        rc5_pkg::A_HOLD:   a_nxt = a_r;
        rc5_pkg::A_ADD_RD: a_nxt = a_r + rd;
        rc5_pkg::A_SUB_RD: a_nxt = a_r - rd;
        rc5_pkg::A_ENC:    a_nxt = rc5_pkg::rotl32(a_r ^ b_r, b_r[4:0]) + rd;
        rc5_pkg::A_DEC:    a_nxt = rc5_pkg::rotr32(a_r - rd, b_r[4:0]) ^ b_r;
        rc5_pkg::A_LOAD_P: a_nxt = rc5_pkg::MAGIC_P;
        rc5_pkg::A_ADD_Q:  a_nxt = a_r + rc5_pkg::MAGIC_Q;
        rc5_pkg::A_ZERO:   a_nxt = '0;
        rc5_pkg::A_MIX:    a_nxt = rc5_pkg::rotl32(rd + ab_sum, 5'd3);
        default:           a_nxt = a_r;
      endcase
    end
  end

  always_comb begin
    b_nxt = b_r;
    if (in_acc) begin
      b_nxt = in_data.in_right;
    end else begin
      unique case (ctrl.b_op)
        rc5_pkg::B_HOLD:   b_nxt = b_r;
        rc5_pkg::B_ADD_RD: b_nxt = b_r + rd;
        rc5_pkg::B_SUB_RD: b_nxt = b_r - rd;
        rc5_pkg::B_ENC:    b_nxt = rc5_pkg::rotl32(b_r ^ a_r, a_r[4:0]) + rd;
        rc5_pkg::B_DEC:    b_nxt = rc5_pkg::rotr32(b_r - rd, a_r[4:0]) ^ a_r;
        rc5_pkg::B_ZERO:   b_nxt = '0;
        rc5_pkg::B_MIX:    b_nxt = rc5_pkg::rotl32(ks_r[j_r] + ab_sum, ab_sum[4:0]);
        default:           b_nxt = b_r;
      endcase
    end
  end

  // table pointer; the read port always fetches the entry the next step uses
  always_comb begin
    i_nxt = i_r;
    if (in_acc) begin
      i_nxt = (in_data.operation == rc5_pkg::OP_DEC) ? PTR_LAST : '0;
    end else begin
      unique case (ctrl.ptr_op)
        rc5_pkg::PTR_HOLD: i_nxt = i_r;
        rc5_pkg::PTR_INC:  i_nxt = (i_r == PTR_LAST) ? '0 : i_r + 1'b1;
        rc5_pkg::PTR_DEC:  i_nxt = (i_r == '0) ? PTR_LAST : i_r - 1'b1;
        default:           i_nxt = i_r;
      endcase
    end
  end

  always_comb begin
    j_nxt = j_r;
    if (ctrl.ks_load) begin
      j_nxt = '0;
    end else if (ctrl.ks_wr) begin
      j_nxt = j_r + 1'b1;
    end
  end

  // fill writes the running constant, mixing writes the new a word
  assign wdata = (ctrl.a_op == rc5_pkg::A_MIX) ? a_nxt : a_r;

  rc5_ram #(
    .WIDTH (32),
    .DEPTH (rc5_pkg::TABLE_WORDS)
  ) u_round_keys (
    .clk   (clk),
    .we    (ctrl.ram_we),
    .waddr (i_r),
    .wdata (wdata),
    .raddr (i_nxt),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    if (ctrl.ks_load) begin
      for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) begin
        ks_r[k] <= key_words[k];
      end
    end else if (ctrl.ks_wr) begin
      ks_r[j_r] <= b_nxt;
    end
    if (ctrl.out_en) begin
      out_r.out_left  <= ctrl.out_blk ? a_r : '0;
      out_r.out_right <= ctrl.out_blk ? b_r : '0;
      out_r.status    <= ctrl.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r          <= '0;
      j_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      out_strobe_r <= ctrl.out_en;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `RC5_ASSERT(a_ptr_range, clk, rst_n, i_r <= PTR_LAST, "table pointer out of range")
  `RC5_ASSERT(a_fault_zero, clk, rst_n, out_strobe_r && out_r.status |-> out_r.out_left == 32'd0 && out_r.out_right == 32'd0, "fault result carries data")
  `RC5_ASSERT(a_strobe_follows, clk, rst_n, ctrl.out_en |=> out_strobe_r, "result step without strobe")

endmodule

`default_nettype wire

FILE: bench/rc5_block_cipher_checker.sv
// ----------------------------------------------------------------------------
// rc5 block cipher result checker
// watches the request, result and key-register channels, predicts each
// result from its own copy of the key words and round-key table, and
// compares every result field with the oldest prediction in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc5_block_cipher_checker
  import rc5_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_data,
  input  logic              out_strobe,
  input  out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending
);

  logic [31:0] key_regs [KEY_WORDS];
  logic [31:0] mix_words [KEY_WORDS];
  logic [31:0] sched [TABLE_WORDS];
  bit          sched_built;
  out_item_t   awaited_blocks [$];

  function automatic logic [31:0] spin_left(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] spin_right(logic [31:0] x, logic [31:0] n);
    logic [4:0] s;
    s = n[4:0];
    if (s == 5'd0) return x;
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic void build_round_keys();
    logic [31:0] a, b;
    int          i, j;
    for (int k = 0; k < KEY_WORDS; k++) mix_words[k] = key_regs[k];
    sched[0] = MAGIC_P;
    for (int k = 1; k < TABLE_WORDS; k++) sched[k] = sched[k-1] + MAGIC_Q;
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    // three passes over the larger of table and key
    for (int k = 0; k < MIX_STEPS; k++) begin
      sched[i] = spin_left(sched[i] + a + b, 32'd3);
      a = sched[i];
      mix_words[j] = spin_left(mix_words[j] + a + b, a + b);
      b = mix_words[j];
      i = (i + 1) % TABLE_WORDS;
      j = (j + 1) % KEY_WORDS;
    end
    sched_built = 1'b1;
  endfunction

  function automatic out_item_t cipher_result(in_item_t req);
    out_item_t   res;
    logic [31:0] a, b;
    res = '0;
    a = req.in_left;
    b = req.in_right;
    if (req.operation == OP_EXPAND) begin
      build_round_keys();
      return res;
    end
    if (req.operation == OP_NONE) return res;
    if (!sched_built) begin
      res.status = 1'b1;
      return res;
    end
    if (req.operation == OP_ENC) begin
      a = a + sched[0];
      b = b + sched[1];
      for (int r = 1; r <= ROUNDS; r++) begin
        a = spin_left(a ^ b, b) + sched[2*r];
        b = spin_left(b ^ a, a) + sched[2*r+1];
      end
    end else begin
      for (int r = ROUNDS; r >= 1; r--) begin
        b = spin_right(b - sched[2*r+1], a) ^ a;
        a = spin_right(a - sched[2*r], b) ^ b;
      end
      a = a - sched[0];
      b = b - sched[1];
    end
    res.out_left  = a;
    res.out_right = b;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : sample
    out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < KEY_WORDS; k++) key_regs[k] = '0;
      sched_built = 1'b0;
      awaited_blocks.delete();
    end else begin
      if (psel && penable && pwrite && pready)
        key_regs[paddr[CFG_AW-1:2]] = pwdata;
      if (out_strobe) begin
        if (awaited_blocks.size() == 0) begin
          report_mismatch($sformatf("result %h/%h/%b with no request in flight",
                                    out_data.out_left, out_data.out_right,
                                    out_data.status));
        end else begin
          want = awaited_blocks.pop_front();
          if (out_data.out_left !== want.out_left)
            report_mismatch($sformatf("out_left got %h want %h",
                                      out_data.out_left, want.out_left));
          if (out_data.out_right !== want.out_right)
            report_mismatch($sformatf("out_right got %h want %h",
                                      out_data.out_right, want.out_right));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %b want %b",
                                      out_data.status, want.status));
        end
      end
      // a request can be taken in the same cycle as the previous result
      if (start && !busy) awaited_blocks.push_back(cipher_result(in_data));
    end
    pending = awaited_blocks.size();
  end

endmodule

FILE: bench/rc5_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// rc5 block cipher testbench
// drives encrypt, decrypt, expand and unused requests with random gaps
// across several key settings; a separate checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc5_block_cipher_tb;
  import rc5_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_data;
  logic              out_strobe;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                errors;
  int                pending;
  int                quiet;

  always #4 clk = ~clk;

  rc5_block_cipher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  rc5_block_cipher_checker cipher_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .errors     (errors),
    .pending    (pending)
  );

  // stall watchdog: anything taken on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 250);
  endfunction

  function automatic op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 46) return OP_ENC;
    if (r < 92) return OP_DEC;
    if (r < 96) return OP_EXPAND;
    return OP_NONE;
  endfunction

  function automatic logic [31:0] pick_key_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hffffffff;
    return $urandom;
  endfunction

  // no_gap keeps start up straight into the next request
  task automatic send_request(op_t op, logic [31:0] left, logic [31:0] right, bit no_gap);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= '{operation: op, in_left: left, in_right: right};
    do @(posedge clk); while (busy);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(int index, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * index);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic write_keys(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3);
    write_reg(0, k0);
    write_reg(1, k1);
    write_reg(2, k2);
    write_reg(3, k3);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    bit burst;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // table not built yet: both block operations report the fault
    send_request(OP_ENC, 32'h0, 32'h0, 0);
    send_request(OP_DEC, 32'hffffffff, 32'hffffffff, 0);
    send_request(OP_NONE, 32'hffffffff, 32'hffffffff, 0);
    send_request(OP_EXPAND, 32'h0, 32'h0, 0);
    send_request(OP_ENC, 32'h0, 32'h0, 1);
    send_request(OP_ENC, 32'hffffffff, 32'hffffffff, 0);
    send_request(OP_DEC, 32'h0, 32'h0, 0);
    send_request(OP_DEC, 32'hffffffff, 32'hffffffff, 1);
    send_request(OP_ENC, 32'h00000001, 32'h80000000, 0);
    send_request(OP_NONE, 32'h0, 32'h0, 0);
    wait_idle();

    // new key stays out of use until the next expand
    write_keys(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_request(OP_ENC, 32'h55555555, 32'haaaaaaaa, 0);
    send_request(OP_EXPAND, 32'h12345678, 32'h9abcdef0, 0);
    send_request(OP_ENC, 32'h0, 32'h0, 0);
    send_request(OP_DEC, 32'haaaaaaaa, 32'h55555555, 0);
    wait_idle();

    write_keys(32'h03020100, 32'h07060504, 32'h0b0a0908, 32'h0f0e0d0c);
    send_request(OP_DEC, 32'h80000000, 32'h00000001, 0);
    send_request(OP_EXPAND, 32'hffffffff, 32'hffffffff, 1);
    send_request(OP_ENC, 32'h00000000, 32'hffffffff, 0);
    send_request(OP_NONE, 32'h5a5a5a5a, 32'ha5a5a5a5, 0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_keys(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
      // one phase keeps running on the previous table
      if (p != 3) send_request(OP_EXPAND, $urandom, $urandom, 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        burst = (n % 100) < 20;
        if (p == 2 && n == PHASE_ITEMS / 2) wait_idle();
        send_request(pick_op(), $urandom, $urandom, burst);
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
